### src/mfb_pkg.sv
// Shared types and codes for the monochrome framebuffer draw engine.
// No dependencies; the draw engine top level and the store controller import this package.
package mfb_pkg;

   // Bits in one framebuffer byte (eight pixels, most significant bit first).
   localparam int BYTE_BITS = 8;

   // Drawing commands carried by an input item.
   typedef enum logic [2:0] {
      CMD_CLEAR       = 3'd0,
      CMD_PLOT        = 3'd1,
      CMD_READ        = 3'd2,
      CMD_OUTLINE     = 3'd3,
      CMD_FILL        = 3'd4,
      CMD_GLYPH_START = 3'd5,
      CMD_GLYPH_BYTE  = 3'd6,
      CMD_NOP         = 3'd7
   } command_type;

   // One input item.
   typedef struct packed {
      command_type        command;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic [14:0]        extent_w;
      logic [14:0]        extent_h;
      logic               ink;
      logic [7:0]         glyph_byte;
   } req_item_type;

   // One result item.
   typedef struct packed {
      logic pixel_value;
      logic glyph_done;
   } rsp_item_type;

   // Operations of the store controller.
   typedef enum logic [1:0] {
      SOP_FILL = 2'd0,
      SOP_SPAN = 2'd1,
      SOP_READ = 2'd2
   } store_op_type;

   // Control from the sequencer to the store controller.
   typedef struct packed {
      store_op_type op;
      logic         ink;
   } store_cmd_type;

   // Status from the store controller back to the sequencer.
   typedef struct packed {
      logic ready;
      logic pixel;
   } store_status_type;

endpackage

### src/mono_framebuffer_draw_engine.sv
// Top level of the monochrome framebuffer draw engine: command sequencer, clipping,
// glyph state and result register. Depends on mfb_pkg and mfb_store_ctrl.
//
// Usage: a request item (req_valid/req_stall/req_item) carries one drawing command;
// every item produces exactly one result item (rsp_valid/rsp_stall/rsp_item) holding
// the pixel read by a read command and the glyph completion flag.
// The framebuffer is PANEL_WIDTH x PANEL_HEIGHT pixels, rows packed into bytes MSB
// first, held in one RAM of ((PANEL_WIDTH+7)/8)*PANEL_HEIGHT bytes.
// One item is handled at a time; req_stall is low only while the engine is idle.
// Plots, fills, outlines and glyph bits write by byte read-modify-write on the
// single RAM port pair; an off-panel plot or read skips the store, and a glyph
// byte with no glyph active only returns a result. An outline draws up to four
// sides, the side columns one byte per row; a clear writes one RAM byte per cycle.
// After reset the engine clears the whole framebuffer, one byte per cycle; req_stall
// falls once that clear has finished.
// A result waits in the output register while rsp_stall is high; the engine may
// accept the next item meanwhile, and holds that item's result until the register frees.
module mono_framebuffer_draw_engine import mfb_pkg::*; #(
   parameter int PANEL_WIDTH  = 256,
   parameter int PANEL_HEIGHT = 128
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item
);

   localparam int XW = $clog2(PANEL_WIDTH + 1);
   localparam int YW = $clog2(PANEL_HEIGHT + 1);
   localparam int CW = 18;

   localparam logic signed [CW-1:0] ONE       = CW'(1);
   localparam logic signed [CW-1:0] PANEL_W_S = CW'(PANEL_WIDTH);
   localparam logic signed [CW-1:0] PANEL_H_S = CW'(PANEL_HEIGHT);
   localparam logic [7:0]           GLYPH_MAX = 8'hFF;
   localparam logic [2:0]           LAST_BIT  = 3'd7;

   localparam logic [1:0] PART_TOP    = 2'd0;
   localparam logic [1:0] PART_BOTTOM = 2'd1;
   localparam logic [1:0] PART_LEFT   = 2'd2;
   localparam logic [1:0] PART_RIGHT  = 2'd3;

   typedef enum logic [7:0] {
      ST_BOOT  = 8'b00000001,
      ST_IDLE  = 8'b00000010,
      ST_CLIP  = 8'b00000100,
      ST_ISSUE = 8'b00001000,
      ST_WAIT  = 8'b00010000,
      ST_GBIT  = 8'b00100000,
      ST_GADV  = 8'b01000000,
      ST_DONE  = 8'b10000000
   } top_state_type;

   // Half-open rectangle [x0, x1) x [y0, y1) in wide signed coordinates.
   typedef struct packed {
      logic signed [CW-1:0] x0;
      logic signed [CW-1:0] x1;
      logic signed [CW-1:0] y0;
      logic signed [CW-1:0] y1;
   } rect_type;

   function automatic logic signed [CW-1:0] sext16(input logic signed [15:0] v);
      return {{(CW - 16){v[15]}}, v};
   endfunction

   function automatic logic signed [CW-1:0] zext15(input logic [14:0] v);
      return {{(CW - 15){1'b0}}, v};
   endfunction

   function automatic rect_type make_box(input logic signed [CW-1:0] x,
                                         input logic signed [CW-1:0] y,
                                         input logic signed [CW-1:0] w,
                                         input logic signed [CW-1:0] h);
      rect_type r;
      r.x0 = x;
      r.x1 = x + w;
      r.y0 = y;
      r.y1 = y + h;
      return r;
   endfunction

   // One side of a rectangle outline.
   function automatic rect_type outline_part(input req_item_type it, input logic [1:0] part);
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [CW-1:0] w;
      logic signed [CW-1:0] h;
      rect_type             r;
      x = sext16(it.pos_x);
      y = sext16(it.pos_y);
      w = zext15(it.extent_w);
      h = zext15(it.extent_h);
      case (part)
         PART_TOP:    r = make_box(x, y, w, ONE);
         PART_BOTTOM: r = make_box(x, y + h - ONE, w, ONE);
         PART_LEFT:   r = make_box(x, y, ONE, h);
         PART_RIGHT:  r = make_box(x + w - ONE, y, ONE, h);
         default:     r = make_box(x, y, ONE, h);
      endcase
      return r;
   endfunction

   function automatic logic [7:0] sat8(input logic [14:0] v);
      return (v > 15'd255) ? GLYPH_MAX : v[7:0];
   endfunction

   top_state_type      state_ff, state_in;
   req_item_type       req_ff, req_in;
   rect_type           rect_ff, rect_in;
   logic [1:0]         part_ff, part_in;
   logic [YW-1:0]      row_ff, row_in;
   logic [YW-1:0]      row_end_ff, row_end_in;
   logic [XW-1:0]      col_lo_ff, col_lo_in;
   logic [XW-1:0]      col_hi_ff, col_hi_in;
   logic [2:0]         bit_ff, bit_in;
   logic               pix_ff, pix_in;
   logic               done_ff, done_in;
   logic signed [15:0] gox_ff, gox_in;
   logic signed [15:0] goy_ff, goy_in;
   logic [7:0]         gw_ff, gw_in;
   logic [7:0]         gh_ff, gh_in;
   logic [7:0]         gcol_ff, gcol_in;
   logic [7:0]         grow_ff, grow_in;
   logic               gcolour_ff, gcolour_in;
   logic               gactive_ff, gactive_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_item_type       rsp_item_ff, rsp_item_in;

   logic signed [CW-1:0] cx_lo, cx_hi, cy_lo, cy_hi;
   logic                 clip_ok;
   logic                 finish_part;
   logic [YW-1:0]        row_next;
   logic [8:0]           gcol_inc, grow_inc;
   logic                 sc_start;
   store_cmd_type        sc_cmd;
   store_status_type     sc_status;

   mfb_store_ctrl #(
      .PANEL_WIDTH  (PANEL_WIDTH),
      .PANEL_HEIGHT (PANEL_HEIGHT)
   ) u_store (
      .clock  (clock),
      .reset  (reset),
      .start  (sc_start),
      .cmd    (sc_cmd),
      .row    (row_ff),
      .col_lo (col_lo_ff),
      .col_hi (col_hi_ff),
      .status (sc_status)
   );

   // Clip the current rectangle to the panel.
   always_comb begin
      cx_lo   = ($signed(rect_ff.x0) < 0) ? '0 : rect_ff.x0;
      cx_hi   = ($signed(rect_ff.x1) > PANEL_W_S) ? PANEL_W_S : rect_ff.x1;
      cy_lo   = ($signed(rect_ff.y0) < 0) ? '0 : rect_ff.y0;
      cy_hi   = ($signed(rect_ff.y1) > PANEL_H_S) ? PANEL_H_S : rect_ff.y1;
      clip_ok = ($signed(cx_lo) < $signed(cx_hi)) && ($signed(cy_lo) < $signed(cy_hi));
   end

   assign row_next = row_ff + 1'b1;
   assign gcol_inc = {1'b0, gcol_ff} + 9'd1;
   assign grow_inc = {1'b0, grow_ff} + 9'd1;

   // Store command follows the item being worked on.
   always_comb begin
      case (req_ff.command)
         CMD_CLEAR: sc_cmd.op = SOP_FILL;
         CMD_READ:  sc_cmd.op = SOP_READ;
         default:   sc_cmd.op = SOP_SPAN;
      endcase
      sc_cmd.ink = (req_ff.command == CMD_GLYPH_BYTE) ? gcolour_ff : req_ff.ink;
   end

   // Command sequencer.
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      rect_in      = rect_ff;
      part_in      = part_ff;
      row_in       = row_ff;
      row_end_in   = row_end_ff;
      col_lo_in    = col_lo_ff;
      col_hi_in    = col_hi_ff;
      bit_in       = bit_ff;
      pix_in       = pix_ff;
      done_in      = done_ff;
      gox_in       = gox_ff;
      goy_in       = goy_ff;
      gw_in        = gw_ff;
      gh_in        = gh_ff;
      gcol_in      = gcol_ff;
      grow_in      = grow_ff;
      gcolour_in   = gcolour_ff;
      gactive_in   = gactive_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_item_in  = rsp_item_ff;
      sc_start     = 1'b0;
      finish_part  = 1'b0;
      case (state_ff)
         ST_BOOT: begin
            if (sc_status.ready) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               req_in  = req_item;
               pix_in  = 1'b0;
               done_in = 1'b0;
               part_in = PART_TOP;
               rect_in = make_box(sext16(req_item.pos_x), sext16(req_item.pos_y), ONE, ONE);
               case (req_item.command)
                  CMD_CLEAR: begin
                     state_in = ST_ISSUE;
                  end
                  CMD_PLOT, CMD_READ: begin
                     state_in = ST_CLIP;
                  end
                  CMD_OUTLINE: begin
                     rect_in  = outline_part(req_item, PART_TOP);
                     state_in = ((req_item.extent_w != '0) && (req_item.extent_h != '0)) ?
                                ST_CLIP : ST_DONE;
                  end
                  CMD_FILL: begin
                     rect_in  = make_box(sext16(req_item.pos_x), sext16(req_item.pos_y),
                                         zext15(req_item.extent_w),
                                         zext15(req_item.extent_h));
                     state_in = ((req_item.extent_w != '0) && (req_item.extent_h != '0)) ?
                                ST_CLIP : ST_DONE;
                  end
                  CMD_GLYPH_START: begin
                     gox_in     = req_item.pos_x;
                     goy_in     = req_item.pos_y;
                     gw_in      = sat8(req_item.extent_w);
                     gh_in      = sat8(req_item.extent_h);
                     gcol_in    = '0;
                     grow_in    = '0;
                     gcolour_in = req_item.ink;
                     gactive_in = (req_item.extent_w != '0) && (req_item.extent_h != '0);
                     done_in    = (req_item.extent_w == '0) || (req_item.extent_h == '0);
                     state_in   = ST_DONE;
                  end
                  CMD_GLYPH_BYTE: begin
                     bit_in   = LAST_BIT;
                     state_in = gactive_ff ? ST_GBIT : ST_DONE;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_CLIP: begin
            if (clip_ok) begin
               row_in     = cy_lo[YW-1:0];
               row_end_in = cy_hi[YW-1:0];
               col_lo_in  = cx_lo[XW-1:0];
               col_hi_in  = cx_hi[XW-1:0];
               state_in   = ST_ISSUE;
            end else begin
               finish_part = 1'b1;
            end
         end
         ST_ISSUE: begin
            sc_start = 1'b1;
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (sc_status.ready) begin
               if (req_ff.command == CMD_CLEAR) begin
                  state_in = ST_DONE;
               end else if (req_ff.command == CMD_READ) begin
                  pix_in   = sc_status.pixel;
                  state_in = ST_DONE;
               end else if (row_next < row_end_ff) begin
                  row_in   = row_next;
                  state_in = ST_ISSUE;
               end else begin
                  finish_part = 1'b1;
               end
            end
         end
         ST_GBIT: begin
            // A set bitmap bit plots one pixel at the glyph cursor.
            rect_in = make_box(sext16(gox_ff) + CW'(gcol_ff), sext16(goy_ff) + CW'(grow_ff),
                               ONE, ONE);
            state_in = req_ff.glyph_byte[bit_ff] ? ST_CLIP : ST_GADV;
         end
         ST_GADV: begin
            // Step the glyph cursor; the glyph ends after its last row.
            state_in = (bit_ff == '0) ? ST_DONE : ST_GBIT;
            bit_in   = bit_ff - 1'b1;
            if (gcol_inc >= {1'b0, gw_ff}) begin
               gcol_in = '0;
               grow_in = grow_inc[7:0];
               if (grow_inc >= {1'b0, gh_ff}) begin
                  gactive_in = 1'b0;
                  done_in    = 1'b1;
                  state_in   = ST_DONE;
               end
            end else begin
               gcol_in = gcol_inc[7:0];
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in            = 1'b1;
               rsp_item_in.pixel_value = pix_ff;
               rsp_item_in.glyph_done  = done_ff;
               state_in                = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // After one rectangle: the next outline side, the next glyph bit, or the result.
      if (finish_part) begin
         if ((req_ff.command == CMD_OUTLINE) && (part_ff != PART_RIGHT)) begin
            part_in  = part_ff + 1'b1;
            rect_in  = outline_part(req_ff, part_ff + 1'b1);
            state_in = ST_CLIP;
         end else if (req_ff.command == CMD_GLYPH_BYTE) begin
            state_in = ST_GADV;
         end else begin
            state_in = ST_DONE;
         end
      end
   end

   // Control and glyph state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_BOOT;
         rsp_valid_ff <= 1'b0;
         gox_ff       <= '0;
         goy_ff       <= '0;
         gw_ff        <= '0;
         gh_ff        <= '0;
         gcol_ff      <= '0;
         grow_ff      <= '0;
         gcolour_ff   <= 1'b0;
         gactive_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         gox_ff       <= gox_in;
         goy_ff       <= goy_in;
         gw_ff        <= gw_in;
         gh_ff        <= gh_in;
         gcol_ff      <= gcol_in;
         grow_ff      <= grow_in;
         gcolour_ff   <= gcolour_in;
         gactive_ff   <= gactive_in;
      end
   end

   // Working registers of the current item.
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      rect_ff     <= rect_in;
      part_ff     <= part_in;
      row_ff      <= row_in;
      row_end_ff  <= row_end_in;
      col_lo_ff   <= col_lo_in;
      col_hi_ff   <= col_hi_in;
      bit_ff      <= bit_in;
      pix_ff      <= pix_in;
      done_ff     <= done_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

### src/mfb_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module mfb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic                                        rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; the read data is registered.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/mfb_store_ctrl.sv
// Framebuffer store controller: owns the byte RAM and performs fills, masked row spans
// by byte read-modify-write, and single pixel reads. Depends on mfb_pkg and mfb_ram.
module mfb_store_ctrl import mfb_pkg::*; #(
   parameter int PANEL_WIDTH  = 256,
   parameter int PANEL_HEIGHT = 128
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  store_cmd_type                        cmd,
   input  logic [$clog2(PANEL_HEIGHT + 1)-1:0]  row,
   input  logic [$clog2(PANEL_WIDTH + 1)-1:0]   col_lo,
   input  logic [$clog2(PANEL_WIDTH + 1)-1:0]   col_hi,
   output store_status_type                     status
);

   localparam int XW          = $clog2(PANEL_WIDTH + 1);
   localparam int BW          = XW - 3;
   localparam int ROW_BYTES   = (PANEL_WIDTH + 7) / 8;
   localparam int STORE_BYTES = ROW_BYTES * PANEL_HEIGHT;
   localparam int AW          = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

   typedef enum logic [3:0] {
      SC_IDLE   = 4'b0001,
      SC_FILL   = 4'b0010,
      SC_READ   = 4'b0100,
      SC_MODIFY = 4'b1000
   } sc_state_type;

   sc_state_type   state_ff, state_in;
   store_op_type   op_ff, op_in;
   logic           ink_ff, ink_in;
   logic [XW-1:0]  lo_ff, lo_in;
   logic [XW-1:0]  hi_ff, hi_in;
   logic [AW-1:0]  base_ff, base_in;
   logic [BW-1:0]  byte_ff, byte_in;
   logic [BW-1:0]  last_ff, last_in;
   logic [AW-1:0]  fill_ff, fill_in;
   logic           pix_ff, pix_in;

   logic [XW-1:0]         hi_m1;
   logic [AW-1:0]         byte_addr;
   logic [BYTE_BITS-1:0]  mask;
   logic                  ram_wr_en;
   logic [AW-1:0]         ram_wr_addr;
   logic [BYTE_BITS-1:0]  ram_wr_data;
   logic                  ram_rd_en;
   logic [BYTE_BITS-1:0]  ram_rd_data;

   mfb_ram #(
      .WIDTH (BYTE_BITS),
      .DEPTH (STORE_BYTES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (byte_addr),
      .rd_data (ram_rd_data)
   );

   assign hi_m1     = col_hi - 1'b1;
   assign byte_addr = base_ff + AW'(byte_ff);

   // Pixels of the current byte that fall inside the span [lo, hi).
   always_comb begin
      logic [XW-1:0] pos;
      pos = '0;
      for (int i = 0; i < BYTE_BITS; i++) begin
         pos = {byte_ff, 3'(i)};
         mask[BYTE_BITS-1-i] = (pos >= lo_ff) && (pos < hi_ff);
      end
   end

   // Sequencing of fills and read-modify-write passes. Each byte is read and then
   // written back before the next read, so accesses never overlap.
   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      ink_in      = ink_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      base_in     = base_ff;
      byte_in     = byte_ff;
      last_in     = last_ff;
      fill_in     = fill_ff;
      pix_in      = pix_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = byte_addr;
      ram_wr_data = ram_rd_data;
      ram_rd_en   = 1'b0;
      case (state_ff)
         SC_IDLE: begin
            if (start) begin
               op_in  = cmd.op;
               ink_in = cmd.ink;
               if (cmd.op == SOP_FILL) begin
                  fill_in  = '0;
                  state_in = SC_FILL;
               end else begin
                  lo_in    = col_lo;
                  hi_in    = col_hi;
                  base_in  = AW'(row * ROW_BYTES);
                  byte_in  = col_lo[XW-1:3];
                  last_in  = hi_m1[XW-1:3];
                  state_in = SC_READ;
               end
            end
         end
         SC_FILL: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = fill_ff;
            ram_wr_data = {BYTE_BITS{ink_ff}};
            if (fill_ff == AW'(STORE_BYTES - 1)) begin
               state_in = SC_IDLE;
            end else begin
               fill_in = fill_ff + 1'b1;
            end
         end
         SC_READ: begin
            ram_rd_en = 1'b1;
            state_in  = SC_MODIFY;
         end
         SC_MODIFY: begin
            if (op_ff == SOP_READ) begin
               pix_in   = ram_rd_data[~lo_ff[2:0]];
               state_in = SC_IDLE;
            end else begin
               ram_wr_en   = 1'b1;
               ram_wr_data = ink_ff ? (ram_rd_data | mask) : (ram_rd_data & ~mask);
               if (byte_ff == last_ff) begin
                  state_in = SC_IDLE;
               end else begin
                  byte_in  = byte_ff + 1'b1;
                  state_in = SC_READ;
               end
            end
         end
         default: begin
            state_in = SC_IDLE;
         end
      endcase
   end

   // Reset starts a zero fill of the whole store.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SC_FILL;
         fill_ff  <= '0;
         ink_ff   <= 1'b0;
         op_ff    <= SOP_FILL;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         ink_ff   <= ink_in;
         op_ff    <= op_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      base_ff <= base_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
      pix_ff  <= pix_in;
   end

   assign status.ready = (state_ff == SC_IDLE);
   assign status.pixel = pix_ff;

endmodule

### bench/mono_framebuffer_draw_engine_tb.sv
// Self-checking testbench for the monochrome framebuffer draw engine: a directed table
// followed by random drawing traffic, checked against a byte-level framebuffer model or a
// hand-written result. Depends on mfb_pkg and the mono_framebuffer_draw_engine RTL.
module mono_framebuffer_draw_engine_tb;
   import mfb_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLOCK_PERIOD     = 8;
   localparam int RESET_CYCLES     = 11;
   localparam int PANEL_W          = 256;
   localparam int PANEL_H          = 128;
   localparam int ROW_BYTES        = (PANEL_W + 7) / 8;
   localparam int STORE_BYTES      = ROW_BYTES * PANEL_H;
   localparam int RANDOM_PER_PHASE = 160;
   localparam int DRAIN_CYCLES     = 64;
   // The limit lies well above a clean run, even with full-panel fills, clears and the
   // clearing pass after reset.
   localparam int CYCLE_LIMIT      = 3_000_000;

   // One row of stimulus, with an optional hand-written expected result.
   typedef struct {
      req_item_type item;
      bit           fixed;
      rsp_item_type want;
   } stim_row_type;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_item  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_item;

   // Framebuffer and glyph state of the prediction.
   logic [7:0] frame_bytes [STORE_BYTES];
   int         glyph_x, glyph_y, glyph_w, glyph_h, glyph_col, glyph_row;
   bit         glyph_ink, glyph_busy;

   rsp_item_type expected_results [$];
   bit           cur_fixed;
   rsp_item_type cur_want;
   int           sender_idle_pct, receiver_stall_pct;
   int           error_count, items_sent, results_checked, lit_reads, glyphs_finished;
   int           directed_count;
   int           cycle_count;

   mono_framebuffer_draw_engine #(
      .PANEL_WIDTH (PANEL_W),
      .PANEL_HEIGHT(PANEL_H)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_item (req_item),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_item (rsp_item)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   initial begin
      foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
   end

   // ---------------------------------------------------------------- prediction

   function automatic bit on_panel(int x, int y);
      return x >= 0 && x < PANEL_W && y >= 0 && y < PANEL_H;
   endfunction

   // Pixel (x, y) is bit 7 - (x mod 8) of its byte; rows are packed MSB first.
   function automatic void set_pixel(int x, int y, bit ink);
      int idx;
      if (!on_panel(x, y)) return;
      idx = y * ROW_BYTES + (x >> 3);
      frame_bytes[idx][7 - (x & 7)] = ink;
   endfunction

   function automatic bit get_pixel(int x, int y);
      if (!on_panel(x, y)) return 1'b0;
      return frame_bytes[y * ROW_BYTES + (x >> 3)][7 - (x & 7)];
   endfunction

   function automatic void paint_span(int x, int y, int w, bit ink);
      int lo, hi;
      if (y < 0 || y >= PANEL_H) return;
      lo = (x < 0) ? 0 : x;
      hi = x + w;
      if (hi > PANEL_W) hi = PANEL_W;
      for (int i = lo; i < hi; i++) set_pixel(i, y, ink);
   endfunction

   function automatic void paint_column(int x, int y, int h, bit ink);
      int lo, hi;
      if (x < 0 || x >= PANEL_W) return;
      lo = (y < 0) ? 0 : y;
      hi = y + h;
      if (hi > PANEL_H) hi = PANEL_H;
      for (int i = lo; i < hi; i++) set_pixel(x, i, ink);
   endfunction

   // Applies one drawing command to the predicted framebuffer and returns its result.
   function automatic rsp_item_type draw_command(req_item_type it);
      rsp_item_type r;
      int           x, y, w, h, lo, hi;
      x = $signed(it.pos_x);
      y = $signed(it.pos_y);
      w = int'({17'd0, it.extent_w});
      h = int'({17'd0, it.extent_h});
      r = '0;
      case (it.command)
         CMD_CLEAR: begin
            foreach (frame_bytes[i]) frame_bytes[i] = {8{it.ink}};
         end
         CMD_PLOT: begin
            set_pixel(x, y, it.ink);
         end
         CMD_READ: begin
            r.pixel_value = get_pixel(x, y);
         end
         CMD_OUTLINE: begin
            if (w > 0 && h > 0) begin
               paint_span(x, y, w, it.ink);
               paint_span(x, y + h - 1, w, it.ink);
               paint_column(x, y, h, it.ink);
               paint_column(x + w - 1, y, h, it.ink);
            end
         end
         CMD_FILL: begin
            if (w > 0 && h > 0) begin
               lo = (y < 0) ? 0 : y;
               hi = y + h;
               if (hi > PANEL_H) hi = PANEL_H;
               for (int row_i = lo; row_i < hi; row_i++) paint_span(x, row_i, w, it.ink);
            end
         end
         CMD_GLYPH_START: begin
            // Sizes saturate at 255; an empty glyph is finished on the spot.
            glyph_x    = x;
            glyph_y    = y;
            glyph_w    = (w > 255) ? 255 : w;
            glyph_h    = (h > 255) ? 255 : h;
            glyph_col  = 0;
            glyph_row  = 0;
            glyph_ink  = it.ink;
            glyph_busy = glyph_w != 0 && glyph_h != 0;
            if (!glyph_busy) r.glyph_done = 1'b1;
         end
         CMD_GLYPH_BYTE: begin
            // Bits after the glyph's last bitmap bit are dropped.
            for (int b = 7; b >= 0; b--) begin
               if (glyph_busy) begin
                  if (it.glyph_byte[b])
                     set_pixel(glyph_x + glyph_col, glyph_y + glyph_row, glyph_ink);
                  glyph_col++;
                  if (glyph_col >= glyph_w) begin
                     glyph_col = 0;
                     glyph_row++;
                     if (glyph_row >= glyph_h) begin
                        glyph_busy   = 1'b0;
                        r.glyph_done = 1'b1;
                     end
                  end
               end
            end
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   // ---------------------------------------------------------------- stimulus helpers

   function automatic stim_row_type make_row(command_type c, int x, int y, int w, int h,
                                             bit ink, int gbyte, bit fixed, bit want_pix,
                                             bit want_done);
      stim_row_type s;
      s.item.command          = c;
      s.item.pos_x            = x[15:0];
      s.item.pos_y            = y[15:0];
      s.item.extent_w         = w[14:0];
      s.item.extent_h         = h[14:0];
      s.item.ink              = ink;
      s.item.glyph_byte       = gbyte[7:0];
      s.fixed                 = fixed;
      s.want.pixel_value      = want_pix;
      s.want.glyph_done       = want_done;
      return s;
   endfunction

   // A command placed around the panel edges, mostly with small extents.
   function automatic stim_row_type near_item(command_type c);
      int x, y, w, h;
      x = int'($urandom_range(279)) - 12;
      y = int'($urandom_range(151)) - 12;
      if ($urandom_range(9) == 0) begin
         x = int'($urandom());
         y = int'($urandom());
      end
      w = int'($urandom_range(40));
      h = int'($urandom_range(40));
      if ($urandom_range(11) == 0) begin
         w = int'($urandom_range(32767));
         h = int'($urandom_range(32767));
      end
      return make_row(c, x, y, w, h, 1'($urandom_range(1)), int'($urandom_range(255)),
                      1'b0, 1'b0, 1'b0);
   endfunction

   // Presents one item after a random gap and holds it until it is accepted.
   task automatic send_row(input stim_row_type s);
      @(negedge clock);
      while (int'($urandom_range(99)) < sender_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_item  = s.item;
      cur_fixed = s.fixed;
      cur_want  = s.want;
      req_valid = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Drops valid and holds off until every outstanding result has come back.
   task automatic settle();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_results.size() != 0) @(negedge clock);
   endtask

   // Random traffic: mostly complete glyphs and small shapes, some noise.
   task automatic random_phase(input int quota);
      int           made, pick, gw, gh, nbytes;
      stim_row_type s;
      made = 0;
      while (made < quota) begin
         pick = int'($urandom_range(99));
         if (pick < 35) begin
            gw = ($urandom_range(19) == 0) ? int'($urandom_range(32767, 256))
                                           : int'($urandom_range(12, 1));
            gh = (gw > 255) ? 1 : int'($urandom_range(12, 1));
            if ($urandom_range(24) == 0) gh = 0;
            s = near_item(CMD_GLYPH_START);
            s.item.extent_w = 15'(gw);
            s.item.extent_h = 15'(gh);
            send_row(s);
            made++;
            nbytes = (((gw > 255) ? 255 : gw) * gh + 7) / 8;
            // Now and then the glyph is cut short and abandoned by the next start.
            if ($urandom_range(9) == 0) nbytes = int'($urandom_range(nbytes));
            for (int k = 0; k < nbytes; k++) begin
               if ($urandom_range(7) == 0) begin
                  send_row(near_item($urandom_range(1) ? CMD_PLOT : CMD_READ));
                  made++;
               end
               s = near_item(CMD_GLYPH_BYTE);
               case ($urandom_range(5))
                  0: s.item.glyph_byte = 8'hFF;
                  1: s.item.glyph_byte = 8'h00;
                  default: begin
                  end
               endcase
               send_row(s);
               made++;
            end
            // A stray byte after the glyph; normally ignored by the engine.
            if ($urandom_range(7) == 0) send_row(near_item(CMD_GLYPH_BYTE));
         end else begin
            if (pick < 52)      s = near_item(CMD_PLOT);
            else if (pick < 72) s = near_item(CMD_READ);
            else if (pick < 83) s = near_item(CMD_FILL);
            else if (pick < 91) s = near_item(CMD_OUTLINE);
            else if (pick < 93) s = near_item(CMD_CLEAR);
            else if (pick < 96) s = near_item(CMD_NOP);
            else
               s = make_row(command_type'(3'($urandom())), int'($urandom()), int'($urandom()),
                            int'($urandom_range(32767)), int'($urandom_range(32767)),
                            1'($urandom_range(1)), int'($urandom_range(255)),
                            1'b0, 1'b0, 1'b0);
            send_row(s);
            made++;
         end
      end
   endtask

   // ---------------------------------------------------------------- result side

   // The receiver stalls at random, at the rate of the current phase.
   always @(negedge clock) begin
      rsp_stall = int'($urandom_range(99)) < receiver_stall_pct;
   end

   // Predicts each accepted item and checks each accepted result against the oldest one.
   always @(posedge clock) begin : monitor
      rsp_item_type want, predicted;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $display("%0t: result with no item outstanding: pixel_value=%0b glyph_done=%0b",
                        $realtime, rsp_item.pixel_value, rsp_item.glyph_done);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_item.pixel_value !== want.pixel_value) begin
                  $display("%0t: pixel_value mismatch: expected %0b, got %0b",
                           $realtime, want.pixel_value, rsp_item.pixel_value);
                  error_count++;
               end
               if (rsp_item.glyph_done !== want.glyph_done) begin
                  $display("%0t: glyph_done mismatch: expected %0b, got %0b",
                           $realtime, want.glyph_done, rsp_item.glyph_done);
                  error_count++;
               end
               results_checked++;
               if (want.pixel_value) lit_reads++;
               if (want.glyph_done) glyphs_finished++;
            end
         end
         if (req_valid && !req_stall) begin
            predicted = draw_command(req_item);
            expected_results.push_back(cur_fixed ? cur_want : predicted);
            items_sent++;
         end
      end
   end

   // Hard stop in case the engine hangs.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $realtime, cycle_count, expected_results.size());
      $display("Verification failed");
      $finish;
   end

   // ---------------------------------------------------------------- main sequence

   initial begin
      stim_row_type directed_rows [$];
      int           sender_plan [4];
      int           receiver_plan [4];
      sender_plan   = '{0, 79, 0, 32};
      receiver_plan = '{0, 0, 79, 32};

      // Extremes, clipping, every command, glyph saturation, abandonment and overrun.
      directed_rows.push_back(make_row(CMD_READ, 0, 0, 0, 0, 0, 0, 1, 0, 0));
      directed_rows.push_back(make_row(CMD_READ, 255, 127, 0, 0, 0, 0, 1, 0, 0));
      directed_rows.push_back(make_row(CMD_PLOT, 0, 0, 0, 0, 1, 0, 1, 0, 0));
      directed_rows.push_back(make_row(CMD_READ, 0, 0, 0, 0, 0, 0, 1, 1, 0));
      directed_rows.push_back(make_row(CMD_PLOT, 255, 127, 0, 0, 1, 0, 1, 0, 0));
      directed_rows.push_back(make_row(CMD_READ, 255, 127, 0, 0, 0, 0, 1, 1, 0));
      directed_rows.push_back(make_row(CMD_PLOT, 256, 0, 0, 0, 1, 0, 1, 0, 0));
      directed_rows.push_back(make_row(CMD_READ, 256, 0, 0, 0, 0, 0, 1, 0, 0));
      directed_rows.push_back(make_row(CMD_PLOT, -32768, -32768, 32767, 32767, 1, 255,
                                       1, 0, 0));
      directed_rows.push_back(make_row(CMD_READ, 32767, -1, 0, 0, 0, 0, 1, 0, 0));
      directed_rows.push_back(make_row(CMD_FILL, 0, 0, 0, 5, 1, 0, 1, 0, 0));
      directed_rows.push_back(make_row(CMD_OUTLINE, 0, 0, 256, 128, 1, 0, 0, 0, 0));
      directed_rows.push_back(make_row(CMD_READ, 128, 127, 0, 0, 0, 0, 0, 0, 0));
      directed_rows.push_back(make_row(CMD_READ, 128, 64, 0, 0, 0, 0, 0, 0, 0));
      directed_rows.push_back(make_row(CMD_FILL, 32767, 32767, 32767, 32767, 1, 0, 1, 0, 0));
      directed_rows.push_back(make_row(CMD_FILL, -32768, -32768, 32767, 32767, 0, 0,
                                       1, 0, 0));
      directed_rows.push_back(make_row(CMD_FILL, 100, 50, 20, 10, 1, 0, 0, 0, 0));
      directed_rows.push_back(make_row(CMD_READ, 110, 55, 0, 0, 0, 0, 0, 0, 0));
      directed_rows.push_back(make_row(CMD_CLEAR, 0, 0, 0, 0, 1, 0, 1, 0, 0));
      directed_rows.push_back(make_row(CMD_READ, 37, 90, 0, 0, 0, 0, 1, 1, 0));
      directed_rows.push_back(make_row(CMD_GLYPH_BYTE, 0, 0, 0, 0, 1, 255, 1, 0, 0));
      directed_rows.push_back(make_row(CMD_GLYPH_START, 10, 10, 0, 4, 0, 0, 1, 0, 1));
      directed_rows.push_back(make_row(CMD_GLYPH_START, 10, 10, 32767, 32767, 0, 0,
                                       1, 0, 0));
      directed_rows.push_back(make_row(CMD_GLYPH_START, -2, -1, 3, 2, 0, 0, 1, 0, 0));
      directed_rows.push_back(make_row(CMD_GLYPH_BYTE, 0, 0, 0, 0, 0, 8'hA5, 1, 0, 1));
      directed_rows.push_back(make_row(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      directed_rows.push_back(make_row(CMD_NOP, -1, -1, 32767, 32767, 1, 255, 1, 0, 0));
      directed_rows.push_back(make_row(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 1, 0, 0));
      directed_count = directed_rows.size();

      // Synchronous reset; the engine then clears its RAM before taking items.
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i]) send_row(directed_rows[i]);
      settle();

      // One random phase per idling pattern, fully drained in between.
      for (int phase = 0; phase < 4; phase++) begin
         sender_idle_pct    = sender_plan[phase];
         receiver_stall_pct = receiver_plan[phase];
         random_phase(RANDOM_PER_PHASE);
         settle();
      end

      // Any late result shows up here as one with no item outstanding.
      receiver_stall_pct = 0;
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d items (%0d directed) and checked %0d results in %0d cycles.",
               items_sent, directed_count, results_checked, cycle_count);
      $display("Covered four idling patterns; %0d reads found lit pixels, %0d glyphs ended.",
               lit_reads, glyphs_finished);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d mismatches found", error_count);
         $display("Verification failed");
      end
      $finish;
   end

endmodule

### files.f
src/mfb_pkg.sv
src/mfb_ram.sv
src/mfb_store_ctrl.sv
src/mono_framebuffer_draw_engine.sv
bench/mono_framebuffer_draw_engine_tb.sv
